### design/twcr_pkg.sv
// Package for the textured wall column renderer.
// Holds default sizes, divider widths and the controller/datapath command and status structs.
// No dependencies.
package twcr_pkg;

    localparam int SCREEN_ROWS_DEF  = 64;
    localparam int SCREEN_COLS_DEF  = 1024;
    localparam int TEX_SIZE_DEF     = 64;
    localparam int NUM_TEXTURES_DEF = 4;

    // shared divider: numerator and divisor widths
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;

    // channel masks of a 0xAARRGGBB texel
    localparam logic [31:0] MASK_R = 32'h00ff0000;
    localparam logic [31:0] MASK_G = 32'h0000ff00;
    localparam logic [31:0] MASK_B = 32'h000000ff;

    typedef enum logic [1:0] {
        DIV_Y,
        DIV_R,
        DIV_G,
        DIV_B
    } div_sel_t;

    typedef enum logic [1:0] {
        COL_KEEP,
        COL_CLEAR,
        COL_PASS,
        COL_SHADE
    } col_src_t;

    typedef struct packed {
        logic     latch;
        logic     row_init;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_take;
        logic     fetch;
        logic     texel_take;
        col_src_t col_src;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic span_empty;
        logic div_busy;
        logic div_done;
        logic hit;
        logic shade_on;
        logic row_last;
        logic out_free;
    } status_t;

endpackage

### design/twcr_if.sv
// Channel interfaces for the renderer: request channel and pixel channel.
// Valid/ready handshake; depends on nothing.
interface twcr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [1:0]  tex_select;
    logic [11:0] texel_addr;
    logic [31:0] texel_value;
    logic [9:0]  column;
    logic [15:0] wall_height;
    logic [15:0] wall_hit_frac;
    logic        hit_side;
    logic        ray_x_positive;
    logic        ray_y_negative;
    logic [15:0] wall_distance;

    modport source (
        output valid, req_type, tex_select, texel_addr, texel_value, column,
               wall_height, wall_hit_frac, hit_side, ray_x_positive,
               ray_y_negative, wall_distance,
        input  ready
    );
    modport sink (
        input  valid, req_type, tex_select, texel_addr, texel_value, column,
               wall_height, wall_hit_frac, hit_side, ray_x_positive,
               ray_y_negative, wall_distance,
        output ready
    );
endinterface

interface twcr_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_addr;
    logic [31:0] pixel_color;
    logic        last;

    modport source (
        output valid, pixel_addr, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_addr, pixel_color, last,
        output ready
    );
endinterface

### design/twcr_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses twcr_pkg for default widths.
module twcr_div #(
    parameter int NW = twcr_pkg::DIV_NW,
    parameter int DW = twcr_pkg::DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

### design/twcr_datapath.sv
// Datapath: span and texture coordinates, texture store, shading, output register.
// Uses twcr_pkg and twcr_div.
module twcr_datapath #(
    parameter int SCREEN_ROWS  = twcr_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS  = twcr_pkg::SCREEN_COLS_DEF,
    parameter int TEX_SIZE     = twcr_pkg::TEX_SIZE_DEF,
    parameter int NUM_TEXTURES = twcr_pkg::NUM_TEXTURES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  twcr_pkg::cmd_t      cmd,
    output twcr_pkg::status_t   st,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                load_we,
    input  logic [1:0]          tex_select,
    input  logic [11:0]         texel_addr,
    input  logic [31:0]         texel_value,
    input  logic [9:0]          column,
    input  logic [15:0]         wall_height,
    input  logic [15:0]         wall_hit_frac,
    input  logic                hit_side,
    input  logic                ray_x_positive,
    input  logic                ray_y_negative,
    input  logic [15:0]         wall_distance,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         pixel_addr,
    output logic [31:0]         pixel_color,
    output logic                last
);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int TXW   = $clog2(TEX_SIZE);
    localparam int TT    = TEX_SIZE * TEX_SIZE;
    localparam int DEPTH = NUM_TEXTURES * TT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = twcr_pkg::DIV_NW;

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_q_reg;

    logic signed [7:0] eo_reg;
    logic [1:0]        tex_reg;
    logic [9:0]        col_reg;
    logic [15:0]       h_reg;
    logic [15:0]       dist_reg;
    logic [TXW-1:0]    tx_reg;
    logic [TXW-1:0]    ty_reg;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     end_reg;
    logic [31:0]       texel_reg;
    logic [23:0]       shade_reg;
    logic [31:0]       color_reg;
    logic              out_valid_reg;
    logic [15:0]       paddr_reg;
    logic [31:0]       pcolor_reg;
    logic              last_reg;

    // span bounds
    logic signed [17:0] eo_ext, a_s, a_adj, half_a, s0, e0, sum_h;
    logic [RW-1:0]      start_c, end_c;

    always_comb
    begin
        eo_ext = 18'(eo_reg);
        a_s    = 18'(SCREEN_ROWS) - 18'(h_reg);
        a_adj  = a_s + 18'(a_s[17]);
        half_a = a_adj >>> 1;
        sum_h  = 18'(SCREEN_ROWS) + 18'(h_reg);
        s0     = half_a + eo_ext;
        e0     = (sum_h >>> 1) + eo_ext;
        if (s0 < 0)
            start_c = '0;
        else if (s0 >= 18'(SCREEN_ROWS))
            start_c = RW'(SCREEN_ROWS - 1);
        else
            start_c = s0[RW-1:0];
        if (e0 < 0)
            end_c = '0;
        else if (e0 >= 18'(SCREEN_ROWS))
            end_c = RW'(SCREEN_ROWS - 1);
        else
            end_c = e0[RW-1:0];
    end

    // texture column from the hit fraction, mirrored on two sides
    logic [22:0]    frac_prod;
    logic [TXW-1:0] tx_raw, tx_c;
    always_comb
    begin
        frac_prod = 23'(wall_hit_frac) * 23'(TEX_SIZE);
        tx_raw    = frac_prod[16 +: TXW];
        if ((!hit_side && ray_x_positive) || (hit_side && ray_y_negative))
            tx_c = TXW'(TEX_SIZE - 1) - tx_raw;
        else
            tx_c = tx_raw;
    end

    // texture row numerator: d * TEX_SIZE, sign and magnitude
    logic signed [19:0] d_v;
    logic signed [25:0] dt_v;
    logic [25:0]        dt_mag;
    logic               dt_neg;
    always_comb
    begin
        d_v    = 20'({row_reg, 1'b0}) - 20'(SCREEN_ROWS) + 20'(h_reg)
                 - (20'(eo_reg) <<< 1);
        dt_v   = 26'(d_v) * 26'(TEX_SIZE);
        dt_neg = dt_v[25];
        dt_mag = dt_neg ? 26'(-dt_v) : 26'(dt_v);
    end

    // shared divider
    logic [NW-1:0]  div_num;
    logic [15:0]    div_den;
    logic           div_busy, div_done;
    logic [NW-1:0]  div_quo;
    logic [7:0]     chan;

    always_comb
    begin
        case (cmd.div_sel)
            twcr_pkg::DIV_R: chan = 8'((texel_reg & twcr_pkg::MASK_R) >> 16);
            twcr_pkg::DIV_G: chan = 8'((texel_reg & twcr_pkg::MASK_G) >> 8);
            default:         chan = 8'(texel_reg & twcr_pkg::MASK_B);
        endcase
        if (cmd.div_sel == twcr_pkg::DIV_Y)
        begin
            div_num = dt_mag[NW-1:0];
            div_den = h_reg;
        end
        else
        begin
            div_num = NW'({chan, 8'h00});
            div_den = dist_reg;
        end
    end

    twcr_div #(.NW(NW), .DW(twcr_pkg::DIV_DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // texture row: halve the truncated quotient toward zero, then range check
    logic [NW-2:0] y_mag;
    logic          y_ok, tex_ok;
    always_comb
    begin
        y_mag  = div_quo[NW-1:1];
        y_ok   = dt_neg ? (y_mag == '0) : (y_mag < (NW-1)'(TEX_SIZE));
        tex_ok = 32'(tex_reg) < 32'(NUM_TEXTURES);
    end

    logic [AW-1:0] rd_idx, wr_idx;
    logic          wr_ok;
    always_comb
    begin
        rd_idx = AW'(int'(tex_reg) * TT + int'(ty_reg) * TEX_SIZE + int'(tx_reg));
        wr_idx = AW'(int'(tex_select) * TT + int'(texel_addr));
        wr_ok  = (32'(tex_select) < 32'(NUM_TEXTURES)) && (32'(texel_addr) < 32'(TT));
    end

    always_ff @(posedge clk)
    begin
        if (load_we && wr_ok)
            mem[wr_idx] <= texel_value;
        if (cmd.fetch)
            mem_q_reg <= mem[rd_idx];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            tex_reg  <= tex_select;
            col_reg  <= column;
            h_reg    <= wall_height;
            dist_reg <= wall_distance;
            tx_reg   <= tx_c;
        end
        if (cmd.row_init)
        begin
            row_reg <= start_c;
            end_reg <= end_c;
        end
        else if (cmd.emit)
            row_reg <= row_reg + 1'b1;
        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                twcr_pkg::DIV_Y: ty_reg <= y_mag[TXW-1:0];
                twcr_pkg::DIV_R: shade_reg[23:16] <= div_quo[7:0];
                twcr_pkg::DIV_G: shade_reg[15:8]  <= div_quo[7:0];
                default:         shade_reg[7:0]   <= div_quo[7:0];
            endcase
        end
        if (cmd.texel_take)
            texel_reg <= mem_q_reg;
        case (cmd.col_src)
            twcr_pkg::COL_CLEAR: color_reg <= '0;
            twcr_pkg::COL_PASS:  color_reg <= texel_reg;
            twcr_pkg::COL_SHADE: color_reg <= {8'h00, shade_reg};
            default:             color_reg <= color_reg;
        endcase
        if (cmd.emit)
        begin
            paddr_reg  <= 16'(int'(col_reg) + int'(row_reg) * SCREEN_COLS);
            pcolor_reg <= color_reg;
            last_reg   <= st.row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eo_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                eo_reg <= cfg_wdata;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        st.span_empty = end_c <= start_c;
        st.div_busy   = div_busy;
        st.div_done   = div_done;
        st.hit        = y_ok && tex_ok;
        st.shade_on   = dist_reg > 16'd256;
        st.row_last   = ((RW+1)'(row_reg) + 1'b1) == (RW+1)'(end_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_addr  = paddr_reg;
    assign pixel_color = pcolor_reg;
    assign last        = last_reg;
endmodule

### design/twcr_ctrl.sv
// Controller: sequences load, span setup, per-row division, fetch, shading and emit.
// Uses twcr_pkg command and status structs.
module twcr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_req_type,
    output logic               in_ready,
    input  twcr_pkg::status_t  st,
    output twcr_pkg::cmd_t     cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SPAN, S_YGO, S_YWAIT, S_FETCH, S_TEXEL,
        S_SHCHK, S_SHGO, S_SHWAIT, S_SHEND, S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    twcr_pkg::div_sel_t ch_reg, ch_next;

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cmd         = '0;
        cmd.div_sel = twcr_pkg::DIV_Y;
        cmd.col_src = twcr_pkg::COL_KEEP;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (in_req_type)
                        state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                cmd.row_init = 1'b1;
                cmd.col_src  = twcr_pkg::COL_CLEAR;
                state_next   = st.span_empty ? S_IDLE : S_YGO;
            end
            S_YGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (st.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = st.hit ? S_FETCH : S_EMIT;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_TEXEL;
            end
            S_TEXEL:
            begin
                cmd.texel_take = 1'b1;
                state_next     = S_SHCHK;
            end
            S_SHCHK:
            begin
                if (st.shade_on)
                begin
                    ch_next    = twcr_pkg::DIV_R;
                    state_next = S_SHGO;
                end
                else
                begin
                    cmd.col_src = twcr_pkg::COL_PASS;
                    state_next  = S_EMIT;
                end
            end
            S_SHGO:
            begin
                cmd.div_sel   = ch_reg;
                cmd.div_start = 1'b1;
                state_next    = S_SHWAIT;
            end
            S_SHWAIT:
            begin
                cmd.div_sel = ch_reg;
                if (st.div_done)
                begin
                    cmd.div_take = 1'b1;
                    unique case (ch_reg)
                        twcr_pkg::DIV_R:
                        begin
                            ch_next    = twcr_pkg::DIV_G;
                            state_next = S_SHGO;
                        end
                        twcr_pkg::DIV_G:
                        begin
                            ch_next    = twcr_pkg::DIV_B;
                            state_next = S_SHGO;
                        end
                        default:
                            state_next = S_SHEND;
                    endcase
                end
            end
            S_SHEND:
            begin
                cmd.col_src = twcr_pkg::COL_SHADE;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = st.row_last ? S_IDLE : S_YGO;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= twcr_pkg::DIV_R;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end
endmodule

### design/textured_wall_column_renderer_unit.sv
// Top level of the textured wall column renderer.
// Uses twcr_pkg, twcr_if, twcr_div, twcr_datapath and twcr_ctrl.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid/ready      load texel or draw column request
//   pix_ch    out   valid/ready      pixel_addr, pixel_color, last
//   cfg       in    cfg_we           cfg_wdata = eye_offset
//
// A load is written from the idle state. A draw sets up the span, then per row
// runs the 24-bit serial texture-row divide and emits; a hit adds the texel
// fetch and, when shaded, the per-channel divides in the one shared divider.
// Rows wait in the emit state while the pixel register is full.
// Reset clears the controller, divider and output valid; texture store is
// not cleared.
module textured_wall_column_renderer_unit #(
    parameter int SCREEN_ROWS  = twcr_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS  = twcr_pkg::SCREEN_COLS_DEF,
    parameter int TEX_SIZE     = twcr_pkg::TEX_SIZE_DEF,
    parameter int NUM_TEXTURES = twcr_pkg::NUM_TEXTURES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    twcr_req_if.sink   req_ch,
    twcr_pix_if.source pix_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    twcr_pkg::cmd_t    cmd;
    twcr_pkg::status_t st;
    logic              in_ready;

    twcr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req_ch.valid),
        .in_req_type (req_ch.req_type),
        .in_ready    (in_ready),
        .st          (st),
        .cmd         (cmd)
    );

    twcr_datapath #(
        .SCREEN_ROWS  (SCREEN_ROWS),
        .SCREEN_COLS  (SCREEN_COLS),
        .TEX_SIZE     (TEX_SIZE),
        .NUM_TEXTURES (NUM_TEXTURES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .load_we        (req_ch.valid && in_ready && !req_ch.req_type),
        .tex_select     (req_ch.tex_select),
        .texel_addr     (req_ch.texel_addr),
        .texel_value    (req_ch.texel_value),
        .column         (req_ch.column),
        .wall_height    (req_ch.wall_height),
        .wall_hit_frac  (req_ch.wall_hit_frac),
        .hit_side       (req_ch.hit_side),
        .ray_x_positive (req_ch.ray_x_positive),
        .ray_y_negative (req_ch.ray_y_negative),
        .wall_distance  (req_ch.wall_distance),
        .out_valid      (pix_ch.valid),
        .out_ready      (pix_ch.ready),
        .pixel_addr     (pix_ch.pixel_addr),
        .pixel_color    (pix_ch.pixel_color),
        .last           (pix_ch.last)
    );

    assign req_ch.ready = in_ready;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("pixel emitted into a full output register");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider restarted while busy");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |-> !st.div_busy)
        else $error("request taken while a divide is in flight");
endmodule

### tb/tb.sv
// Self-checking testbench for textured_wall_column_renderer_unit.
// Depends on twcr_pkg, twcr_if and the renderer RTL; drives texel loads and
// column draws, predicts every pixel transfer and compares it field by field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS  = twcr_pkg::SCREEN_ROWS_DEF;
    localparam int COLS  = twcr_pkg::SCREEN_COLS_DEF;
    localparam int TSIZE = twcr_pkg::TEX_SIZE_DEF;
    localparam int NTEX  = twcr_pkg::NUM_TEXTURES_DEF;
    localparam int TWORDS = TSIZE * TSIZE;
    localparam bit REQ_LOAD = 1'b0;
    localparam bit REQ_DRAW = 1'b1;

    typedef struct {
        bit        req_type;
        bit [1:0]  tex_select;
        bit [11:0] texel_addr;
        bit [31:0] texel_value;
        bit [9:0]  column;
        bit [15:0] wall_height;
        bit [15:0] wall_hit_frac;
        bit        hit_side;
        bit        ray_x_positive;
        bit        ray_y_negative;
        bit [15:0] wall_distance;
    } request_t;

    typedef struct {
        bit [15:0] addr;
        bit [31:0] color;
        bit        last;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    twcr_req_if req_ch();
    twcr_pix_if pix_ch();

    textured_wall_column_renderer_unit dut (
        .clk(clk), .rst_n(rst_n), .req_ch(req_ch), .pix_ch(pix_ch),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    request_t  pending_reqs[$];
    pixel_t    expected_pixels[$];
    bit [31:0] texel_mirror[NTEX * TWORDS];
    bit        planned[NTEX * TWORDS];
    int        item_total;
    int        eye_shift;
    int        fails;
    bit        drv_burst;
    bit        snk_burst;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_row(int r);
        if (r < 0) return 0;
        if (r >= ROWS) return ROWS - 1;
        return r;
    endfunction

    function automatic bit [31:0] darken(bit [31:0] texel, bit [15:0] wdist);
        bit [31:0] r, g, b;
        if (wdist <= 16'd256) return texel;
        r = (((texel & twcr_pkg::MASK_R) >> 16) * 256) / wdist;
        g = (((texel & twcr_pkg::MASK_G) >> 8) * 256) / wdist;
        b = ((texel & twcr_pkg::MASK_B) * 256) / wdist;
        return (r << 16) | (g << 8) | b;
    endfunction

    function automatic int tex_col(request_t q);
        int tx;
        tx = (q.wall_hit_frac * TSIZE) >> 16;
        if ((!q.hit_side && q.ray_x_positive) || (q.hit_side && q.ray_y_negative))
            tx = TSIZE - tx - 1;
        return tx;
    endfunction

    function automatic int tex_row(int row, int h);
        int d;
        d = row * 2 - ROWS + h - eye_shift * 2;
        return ((d * TSIZE) / h) / 2;
    endfunction

    // apply one accepted request to the mirror state and queue its pixels
    task automatic render_request(request_t q);
        int h, first, stop, tx, ty;
        bit [31:0] shade_col;
        pixel_t p;
        if (q.req_type == REQ_LOAD) begin
            if (q.tex_select < NTEX && q.texel_addr < TWORDS)
                texel_mirror[q.tex_select * TWORDS + q.texel_addr] = q.texel_value;
            return;
        end
        shade_col = '0;
        h = q.wall_height;
        if (h == 0) return;
        first = clamp_row((ROWS - h) / 2 + eye_shift);
        stop  = clamp_row((ROWS + h) / 2 + eye_shift);
        tx = tex_col(q);
        for (int row = first; row < stop; row++) begin
            ty = tex_row(row, h);
            if (q.tex_select < NTEX && tx >= 0 && tx < TSIZE && ty >= 0 && ty < TSIZE)
                shade_col = darken(texel_mirror[q.tex_select * TWORDS + ty * TSIZE + tx],
                                   q.wall_distance);
            p.addr  = 16'(q.column + row * COLS);
            p.color = shade_col;
            p.last  = (row == stop - 1);
            expected_pixels.push_back(p);
        end
    endtask

    // request driver
    int drv_gap;
    int drv_count;
    always @(posedge clk) begin
        request_t it;
        bit busy;
        if (rst_n) begin
            busy = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                busy = 1'b0;
                it.req_type       = req_ch.req_type;
                it.tex_select     = req_ch.tex_select;
                it.texel_addr     = req_ch.texel_addr;
                it.texel_value    = req_ch.texel_value;
                it.column         = req_ch.column;
                it.wall_height    = req_ch.wall_height;
                it.wall_hit_frac  = req_ch.wall_hit_frac;
                it.hit_side       = req_ch.hit_side;
                it.ray_x_positive = req_ch.ray_x_positive;
                it.ray_y_negative = req_ch.ray_y_negative;
                it.wall_distance  = req_ch.wall_distance;
                render_request(it);
            end
            if (!busy) begin
                if (drv_gap != 0) begin
                    drv_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    it = pending_reqs.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.req_type       <= it.req_type;
                    req_ch.tex_select     <= it.tex_select;
                    req_ch.texel_addr     <= it.texel_addr;
                    req_ch.texel_value    <= it.texel_value;
                    req_ch.column         <= it.column;
                    req_ch.wall_height    <= it.wall_height;
                    req_ch.wall_hit_frac  <= it.wall_hit_frac;
                    req_ch.hit_side       <= it.hit_side;
                    req_ch.ray_x_positive <= it.ray_x_positive;
                    req_ch.ray_y_negative <= it.ray_y_negative;
                    req_ch.wall_distance  <= it.wall_distance;
                    drv_count++;
                    if (drv_count % 23 == 0) drv_burst = ~drv_burst;
                    drv_gap = drv_burst ? 0 : $urandom_range(0, 17);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and checker
    int snk_gap;
    int snk_count;
    always @(posedge clk) begin
        pixel_t e;
        if (rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel transfer addr=%h", pix_ch.pixel_addr);
                    fails++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (pix_ch.pixel_addr !== e.addr) begin
                        $error("pixel_addr expected %h actual %h", e.addr, pix_ch.pixel_addr);
                        fails++;
                    end
                    if (pix_ch.pixel_color !== e.color) begin
                        $error("pixel_color expected %h actual %h",
                               e.color, pix_ch.pixel_color);
                        fails++;
                    end
                    if (pix_ch.last !== e.last) begin
                        $error("last expected %b actual %b", e.last, pix_ch.last);
                        fails++;
                    end
                end
                snk_count++;
                if (snk_count % 97 == 0) snk_burst = ~snk_burst;
                snk_gap = snk_burst ? 0 : $urandom_range(0, 17);
            end
            if (snk_gap != 0) begin
                snk_gap--;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    function automatic request_t draw_req(bit [1:0] tex, bit [9:0] col, bit [15:0] h,
                                          bit [15:0] frac, bit [2:0] sides,
                                          bit [15:0] wdist);
        request_t r;
        r.req_type       = REQ_DRAW;
        r.tex_select     = tex;
        r.texel_addr     = 12'($urandom);
        r.texel_value    = $urandom;
        r.column         = col;
        r.wall_height    = h;
        r.wall_hit_frac  = frac;
        r.hit_side       = sides[2];
        r.ray_x_positive = sides[1];
        r.ray_y_negative = sides[0];
        r.wall_distance  = wdist;
        return r;
    endfunction

    function automatic request_t load_req(bit [1:0] tex, bit [11:0] a, bit [31:0] v);
        request_t r;
        r = draw_req(tex, 10'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
                     16'($urandom));
        r.req_type    = REQ_LOAD;
        r.texel_addr  = a;
        r.texel_value = v;
        return r;
    endfunction

    task automatic push_load(bit [1:0] tex, bit [11:0] a, bit [31:0] v);
        pending_reqs.push_back(load_req(tex, a, v));
        planned[int'(tex) * TWORDS + int'(a)] = 1'b1;
        item_total++;
    endtask

    // queue a load ahead of the draw for every texel it fetches that is not yet written
    task automatic push_draw(request_t r);
        int h, first, stop, tx, ty, idx;
        h = r.wall_height;
        if (h != 0) begin
            first = clamp_row((ROWS - h) / 2 + eye_shift);
            stop  = clamp_row((ROWS + h) / 2 + eye_shift);
            tx = tex_col(r);
            for (int row = first; row < stop; row++) begin
                ty = tex_row(row, h);
                if (ty >= 0 && ty < TSIZE) begin
                    idx = r.tex_select * TWORDS + ty * TSIZE + tx;
                    if (!planned[idx])
                        push_load(r.tex_select, 12'(ty * TSIZE + tx), $urandom);
                end
            end
        end
        pending_reqs.push_back(r);
        item_total++;
    endtask

    // small heights and edge fractions keep the texels a draw needs few
    function automatic request_t random_draw();
        bit [15:0] h, wdist, frac;
        case ($urandom_range(0, 7))
            0:       h = '0;
            1:       h = 16'($urandom);
            2:       h = 16'($urandom_range(2000, 65535));
            default: h = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       wdist = 16'($urandom_range(0, 256));
            1:       wdist = 16'($urandom);
            default: wdist = 16'($urandom_range(257, 2000));
        endcase
        case ($urandom_range(0, 2))
            0:       frac = 16'h0000;
            1:       frac = 16'hffff;
            default: frac = 16'($urandom);
        endcase
        return draw_req(2'($urandom), 10'($urandom), h, frac, 3'($urandom), wdist);
    endfunction

    task automatic push_random();
        if ($urandom_range(0, 4) == 0)
            push_load(2'($urandom), 12'($urandom), $urandom);
        else
            push_draw(random_draw());
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
        // loads and empty spans leave no pixel behind, so give the block time to finish
        repeat (400) @(posedge clk);
    endtask

    task automatic set_eye(int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 8'(v);
        eye_shift = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int eyes[4];
        int target;
        fails = 0;
        item_total = 0;
        eye_shift = 0;
        drv_gap = 0;
        snk_gap = 0;
        drv_count = 0;
        snk_count = 0;
        drv_burst = 1'b1;
        snk_burst = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.tex_select = '0;
        req_ch.texel_addr = '0;
        req_ch.texel_value = '0;
        req_ch.column = '0;
        req_ch.wall_height = '0;
        req_ch.wall_hit_frac = '0;
        req_ch.hit_side = 1'b0;
        req_ch.ray_x_positive = 1'b0;
        req_ch.ray_y_negative = 1'b0;
        req_ch.wall_distance = '0;
        pix_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: span and shading corners
        push_load(0, 12'd0, 32'hffffffff);
        push_draw(draw_req(0, 10'd2, 16'd2, 16'h0000, 3'b000, 16'd257));
        push_draw(draw_req(0, 10'd2, 16'd2, 16'h0000, 3'b000, 16'd256));
        push_draw(draw_req(0, 0, 16'd0, 16'h0000, 3'b000, 16'd256));
        push_draw(draw_req(0, 10'd1023, 16'd1, 16'h0000, 3'b000, 16'd0));
        push_draw(draw_req(1, 10'd1023, 16'd2, 16'hffff, 3'b010, 16'd257));
        push_draw(draw_req(2, 10'd5, 16'd3, 16'hffff, 3'b101, 16'hffff));
        push_draw(draw_req(3, 10'd512, 16'hffff, 16'h8000, 3'b100, 16'd300));
        push_draw(draw_req(0, 10'd2, 16'd4, 16'h0001, 3'b011, 16'd256));
        push_draw(draw_req(1, 10'd3, 16'd5, 16'h7fff, 3'b111, 16'd4096));
        push_draw(draw_req(2, 10'd700, 16'd40000, 16'hc000, 3'b110, 16'd1));
        push_load(3, 12'(31 * TSIZE + 32), 32'h12345678);
        push_draw(draw_req(3, 10'd0, 16'hffff, 16'h8000, 3'b100, 16'd257));
        settle();

        eyes[0] = -64; eyes[1] = 64; eyes[2] = 63; eyes[3] = $urandom_range(0, 128) - 64;
        foreach (eyes[i]) begin
            set_eye(eyes[i]);
            push_draw(draw_req(0, 10'd9, 16'hff00, 16'h4000, 3'b001, 16'd200));
            push_draw(draw_req(1, 10'd9, 16'd6, 16'h2000, 3'b010, 16'd600));
            target = item_total + 12;
            while (item_total < target)
                push_random();
            settle();
        end
        set_eye(0);
        while (item_total < 100)
            push_random();
        settle();

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
